// ===== rtl/sfp_pkg.sv =====
package sfp_pkg;

    localparam int LenBits    = 16;
    localparam int AngBits    = 16;
    localparam int CordSteps  = 16;
    localparam int StepBits   = 4;
    localparam int HundredthRad = 82;
    localparam int QuarterTurn  = 12868;
    localparam logic signed [31:0] CordGain = 32'sd652032874;

    localparam logic [2:0] ADDR_WB   = 3'd0;
    localparam logic [2:0] ADDR_HW   = 3'd1;
    localparam logic [2:0] ADDR_FL   = 3'd2;
    localparam logic [2:0] ADDR_RL   = 3'd3;
    localparam logic [2:0] ADDR_MG   = 3'd4;
    localparam logic [2:0] ADDR_LIM  = 3'd5;

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_CORD  = 7'b0000010,
        ST_DIV   = 7'b0000100,
        ST_SQR   = 7'b0001000,
        ST_ROOT  = 7'b0010000,
        ST_FIN   = 7'b0100000,
        ST_OUT   = 7'b1000000
    } state_t;

    typedef struct packed {
        logic load;
        logic cord_step;
        logic div_init;
        logic div_step;
        logic sqr_load;
        logic root_step;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic straight;
        logic last_step;
        logic div_done;
        logic root_done;
    } stat_t;

    function automatic logic [31:0] atan_q29(input logic [StepBits-1:0] i);
        logic [31:0] v;
        unique case (i)
            4'd0:  v = 32'd421657428;
            4'd1:  v = 32'd248918915;
            4'd2:  v = 32'd131521918;
            4'd3:  v = 32'd66762579;
            4'd4:  v = 32'd33510843;
            4'd5:  v = 32'd16771758;
            4'd6:  v = 32'd8387925;
            4'd7:  v = 32'd4194219;
            4'd8:  v = 32'd2097141;
            4'd9:  v = 32'd1048575;
            4'd10: v = 32'd524288;
            4'd11: v = 32'd262144;
            4'd12: v = 32'd131072;
            4'd13: v = 32'd65536;
            4'd14: v = 32'd32768;
            default: v = 32'd16384;
        endcase
        return v;
    endfunction

endpackage

// ===== rtl/sfp_ctrl.sv =====
module sfp_ctrl
    import sfp_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  start,
    input  stat_t stat,
    input  logic  out_free,
    output cmd_t  cmd,
    output logic  busy
);

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load = 1'b1;
                    state_next = ST_CORD;
                end
            end
            ST_CORD:
            begin
                if (stat.straight)
                    state_next = ST_FIN;
                else
                begin
                    cmd.cord_step = 1'b1;
                    if (stat.last_step)
                        state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                cmd.div_init = 1'b1;
                state_next = ST_SQR;
            end
            ST_SQR:
            begin
                if (stat.div_done)
                begin
                    cmd.sqr_load = 1'b1;
                    state_next = ST_ROOT;
                end
                else
                    cmd.div_step = 1'b1;
            end
            ST_ROOT:
            begin
                if (stat.root_done)
                    state_next = ST_FIN;
                else
                    cmd.root_step = 1'b1;
            end
            ST_FIN:
            begin
                if (out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
                state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    assign busy = (state_reg != ST_IDLE);

    a_onehot: assert property (@(posedge clk) disable iff (!rst_n) $onehot(state_reg))
        else $error("state not one-hot");
    a_start: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE && start) |=> state_reg == ST_CORD)
        else $error("start lost");
    a_fin: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |=> state_reg == ST_OUT)
        else $error("finish lost");

endmodule

// ===== rtl/sfp_dp.sv =====
module sfp_dp
    import sfp_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  cmd_t                cmd,
    output stat_t               stat,
    input  logic signed [AngBits-1:0] angle,
    input  logic [14:0]         wheel_base,
    input  logic [14:0]         half_body_width,
    input  logic [14:0]         front_half_length,
    input  logic [14:0]         rear_half_length,
    input  logic [14:0]         clearance_margin,
    output logic [14:0]         front_x,
    output logic signed [15:0]  rear_x,
    output logic [14:0]         front_left_y,
    output logic signed [15:0]  front_right_y,
    output logic signed [15:0]  rear_right_y,
    output logic [14:0]         rear_left_y
);

    logic signed [32:0] x_reg, x_next, y_reg, y_next;
    logic signed [33:0] z_reg, z_next;
    logic [StepBits-1:0] i_reg, i_next;
    logic [AngBits-1:0] mag;
    logic straight_reg;
    logic [47:0] num_reg;
    logic [31:0] den_reg;
    logic [31:0] q_reg;
    logic [5:0]  cnt_reg;
    logic [48:0] rem_reg;
    logic [63:0] n_reg, res_reg, bit_reg;
    logic [32:0] s_reg;
    logic signed [AngBits-1:0] a_reg;
    logic [14:0] fx_reg, fly_reg, rly_reg;
    logic signed [15:0] rx_reg, fry_reg, rry_reg;

    assign mag = angle[AngBits-1] ? AngBits'(0) - angle : angle;

    logic [48:0] rem_sh;
    logic [48:0] rem_sub;
    logic [63:0] rb;
    logic [32:0] clampx;
    logic [32:0] l_sum;
    logic [32:0] s_w;
    logic [47:0] s_sq, l_sq;

    always_comb
    begin
        x_next = x_reg;
        y_next = y_reg;
        z_next = z_reg;
        i_next = i_reg;
        if (cmd.load)
        begin
            x_next = 33'(CordGain);
            y_next = '0;
            z_next = (mag > AngBits'(QuarterTurn)) ? 34'(QuarterTurn) <<< 16
                                                   : 34'(mag) <<< 16;
            i_next = '0;
        end
        else if (cmd.cord_step)
        begin
            if (!z_reg[33])
            begin
                x_next = x_reg - (y_reg >>> i_reg);
                y_next = y_reg + (x_reg >>> i_reg);
                z_next = z_reg - 34'(atan_q29(i_reg));
            end
            else
            begin
                x_next = x_reg + (y_reg >>> i_reg);
                y_next = y_reg - (x_reg >>> i_reg);
                z_next = z_reg + 34'(atan_q29(i_reg));
            end
            i_next = i_reg + 1'b1;
        end
    end

    assign clampx = x_reg[32] ? 33'd0 : x_reg;
    assign rem_sh = {rem_reg[47:0], num_reg[47]};
    assign rem_sub = rem_sh - 49'(den_reg);
    assign rb = res_reg + bit_reg;
    assign l_sum = 33'(wheel_base) + 33'(front_half_length);
    assign s_w = (den_reg == 32'd0 ? 33'd0 : 33'(q_reg)) + 33'(half_body_width);
    assign s_sq = 48'(s_w[23:0]) * 48'(s_w[23:0]);
    assign l_sq = 48'(l_sum[16:0]) * 48'(l_sum[16:0]);

    always_ff @(posedge clk)
    begin
        x_reg <= x_next;
        y_reg <= y_next;
        z_reg <= z_next;
        i_reg <= i_next;
        if (cmd.load)
        begin
            a_reg <= angle;
            straight_reg <= (mag < AngBits'(HundredthRad));
        end
        if (cmd.div_init)
        begin
            num_reg <= 48'(wheel_base) * 48'(clampx[31:0]);
            den_reg <= y_reg[32] ? 32'd0 : y_reg[31:0];
            rem_reg <= '0;
            q_reg <= '0;
            cnt_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            num_reg <= {num_reg[46:0], 1'b0};
            cnt_reg <= cnt_reg + 1'b1;
            if (!rem_sub[48])
            begin
                rem_reg <= rem_sub;
                q_reg <= {q_reg[30:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_sh;
                q_reg <= {q_reg[30:0], 1'b0};
            end
        end
        if (cmd.sqr_load)
        begin
            s_reg <= s_w;
            n_reg <= 64'(s_sq) + 64'(l_sq);
            res_reg <= '0;
            bit_reg <= 64'h4000_0000_0000_0000;
        end
        else if (cmd.root_step)
        begin
            if (n_reg >= rb)
            begin
                n_reg <= n_reg - rb;
                res_reg <= (res_reg >> 1) + bit_reg;
            end
            else
                res_reg <= res_reg >> 1;
            bit_reg <= bit_reg >> 2;
        end
    end

    assign stat.straight = straight_reg;
    assign stat.last_step = (i_reg == StepBits'(CordSteps - 1));
    assign stat.div_done = (cnt_reg == 6'd48);
    assign stat.root_done = (bit_reg == 64'd0);

    logic signed [34:0] ovd;
    logic [14:0] ov;
    logic [33:0] tail_prod;
    logic [18:0] tail;
    logic [16:0] width;
    logic [18:0] lexp, rexp, lt, rt;
    logic [19:0] fl_sum, fr_sum, rr_sum, rl_sum;
    logic [16:0] fsum, rsum;

    assign ovd = straight_reg ? 35'sd0 : $signed({2'b00, res_reg[32:0]}) - $signed({2'b00, s_reg});
    assign ov = ovd[34] ? 15'd0 : (ovd > 35'(half_body_width) ? half_body_width : ovd[14:0]);
    assign tail_prod = 34'(ov) * 34'd157287;
    assign tail = {4'd0, tail_prod[33:19]};
    assign width = 17'(half_body_width) + 17'(clearance_margin);
    assign rexp = (a_reg >= AngBits'(HundredthRad)) ? 19'(ov) : 19'd0;
    assign lexp = (a_reg <= -AngBits'(HundredthRad)) ? 19'(ov) : 19'd0;
    assign rt = (a_reg > 0) ? tail : 19'd0;
    assign lt = (a_reg < 0) ? tail : 19'd0;
    assign fl_sum = 20'(width) + 20'(lexp);
    assign fr_sum = 20'(width) + 20'(rexp);
    assign rr_sum = 20'(width) + 20'(rt);
    assign rl_sum = 20'(width) + 20'(lt);
    assign fsum = 17'(front_half_length) + 17'(clearance_margin);
    assign rsum = 17'(rear_half_length) + 17'(clearance_margin);

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            fx_reg  <= (fsum > 17'd32767) ? 15'h7FFF : fsum[14:0];
            rx_reg  <= (rsum > 17'd32768) ? -16'sd32768 : 16'(17'd0 - rsum);
            fly_reg <= (fl_sum > 20'd32767) ? 15'h7FFF : fl_sum[14:0];
            fry_reg <= (fr_sum > 20'd32768) ? -16'sd32768 : 16'(20'd0 - fr_sum);
            rry_reg <= (rr_sum > 20'd32768) ? -16'sd32768 : 16'(20'd0 - rr_sum);
            rly_reg <= (rl_sum > 20'd32767) ? 15'h7FFF : rl_sum[14:0];
        end
    end

    assign front_x = fx_reg;
    assign rear_x = rx_reg;
    assign front_left_y = fly_reg;
    assign front_right_y = fry_reg;
    assign rear_right_y = rry_reg;
    assign rear_left_y = rly_reg;

    a_ov: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |-> ov <= half_body_width)
        else $error("overhang out of range");
    a_div: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_init |=> cnt_reg == 6'd0)
        else $error("divider not cleared");
    a_straight: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.cord_step |-> !straight_reg)
        else $error("rotation on straight angle");

endmodule

// ===== rtl/steering_footprint_polygon.sv =====
// Steering footprint polygon generator.
// Input stream s_axis: tuser = req_type (1 = footprint tick, 0 = steering
// update); tdata holds left_present, left_steer, right_present, right_steer.
// A steering update gives no result; updates can follow back to back. A tick
// starts a sequence: 16 rotation steps for sin/cos, one 48-step restoring
// divide for the turn radius and a 32-step bit-pair square root. A turning
// tick shows its result on m_axis after the square root, and the next item
// can be taken once the controller is back in idle. A straight-ahead tick
// skips the math and goes straight to the final step.
// One item is worked at a time; s_axis_tready is low while a tick runs.
// The result waits in an output register on m_axis until taken; a stalled
// receiver holds the next tick in its final step until the register frees.
// Registers are written over the APB port at byte address 4*i; pready is
// always high and reads return the stored value.
// Reset clears the steering angle to zero, loads register defaults and
// empties the output register.
module steering_footprint_polygon
    import sfp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,  // left_present, left_steer, right_present, right_steer
    input  logic        s_axis_tuser,  // req_type
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [95:0] m_axis_tdata   // front_x, rear_x, front_left_y, front_right_y,
                                       // rear_right_y, rear_left_y
);

    logic [14:0] wb_reg, hw_reg, fl_reg, rl_reg, mg_reg;
    logic [13:0] lim_reg;
    logic signed [AngBits-1:0] ang_reg;
    logic ov_reg;
    cmd_t cmd;
    stat_t stat;
    logic busy, start, acc;
    logic [2:0] ridx;

    logic [14:0] front_x, front_left_y, rear_left_y;
    logic signed [15:0] rear_x, front_right_y, rear_right_y;

    assign pready = 1'b1;
    assign ridx = paddr[4:2];
    always_comb
    begin
        unique case (ridx)
            ADDR_WB:  prdata = 32'(wb_reg);
            ADDR_HW:  prdata = 32'(hw_reg);
            ADDR_FL:  prdata = 32'(fl_reg);
            ADDR_RL:  prdata = 32'(rl_reg);
            ADDR_MG:  prdata = 32'(mg_reg);
            ADDR_LIM: prdata = 32'(lim_reg);
            default:  prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wb_reg <= 15'd2908;
            hw_reg <= 15'd942;
            fl_reg <= 15'd1229;
            rl_reg <= 15'd1229;
            mg_reg <= 15'd205;
            lim_reg <= 14'd4915;
        end
        else if (psel && penable && pwrite)
        begin
            unique case (ridx)
                ADDR_WB:  wb_reg <= pwdata[14:0];
                ADDR_HW:  hw_reg <= pwdata[14:0];
                ADDR_FL:  fl_reg <= pwdata[14:0];
                ADDR_RL:  rl_reg <= pwdata[14:0];
                ADDR_MG:  mg_reg <= pwdata[14:0];
                ADDR_LIM: lim_reg <= pwdata[13:0];
                default: ;
            endcase
        end
    end

    assign s_axis_tready = !busy;
    assign acc = s_axis_tvalid && s_axis_tready;
    assign start = acc && s_axis_tuser;

    logic signed [16:0] ls, rs, avg, a_sel, lim_s;
    assign ls = 17'(signed'(s_axis_tdata[16:1]));
    assign rs = 17'(signed'(s_axis_tdata[33:18]));
    assign lim_s = 17'(lim_reg);
    always_comb
    begin
        avg = (ls + rs) >>> 1;
        priority if (s_axis_tdata[0] && s_axis_tdata[17])
            a_sel = avg;
        else if (s_axis_tdata[0])
            a_sel = ls;
        else if (s_axis_tdata[17])
            a_sel = rs;
        else
            a_sel = 17'(ang_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ang_reg <= '0;
        else if (acc && !s_axis_tuser)
        begin
            if (a_sel > lim_s)
                ang_reg <= lim_s[15:0];
            else if (a_sel < -lim_s)
                ang_reg <= 16'(-lim_s);
            else
                ang_reg <= a_sel[15:0];
        end
    end

    sfp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .stat     (stat),
        .out_free (!ov_reg || m_axis_tready),
        .cmd      (cmd),
        .busy     (busy)
    );

    sfp_dp u_dp (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .stat              (stat),
        .angle             (ang_reg),
        .wheel_base        (wb_reg),
        .half_body_width   (hw_reg),
        .front_half_length (fl_reg),
        .rear_half_length  (rl_reg),
        .clearance_margin  (mg_reg),
        .front_x           (front_x),
        .rear_x            (rear_x),
        .front_left_y      (front_left_y),
        .front_right_y     (front_right_y),
        .rear_right_y      (rear_right_y),
        .rear_left_y       (rear_left_y)
    );

    logic fin_d;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ov_reg <= 1'b0;
            fin_d <= 1'b0;
        end
        else
        begin
            fin_d <= cmd.finish;
            if (cmd.finish)
                ov_reg <= 1'b0;
            else if (fin_d)
                ov_reg <= 1'b1;
            else if (m_axis_tready)
                ov_reg <= 1'b0;
        end
    end

    assign m_axis_tvalid = ov_reg;
    assign m_axis_tdata = {3'd0, rear_left_y, rear_right_y, front_right_y,
                           front_left_y, rear_x, front_x};

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
        else $error("result dropped");
    a_lim: assert property (@(posedge clk) disable iff (!rst_n)
        (acc && !s_axis_tuser) |=>
        (17'(ang_reg) <= $past(lim_s)) && (17'(ang_reg) >= -$past(lim_s)))
        else $error("angle over limit");
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> busy)
        else $error("tick not started");

endmodule

// ===== verif/testbench.sv =====
module testbench;
    import sfp_pkg::*;

    typedef struct {
        logic [14:0]        front_x;
        logic signed [15:0] rear_x;
        logic [14:0]        front_left_y;
        logic signed [15:0] front_right_y;
        logic signed [15:0] rear_right_y;
        logic [14:0]        rear_left_y;
    } footprint_t;

    typedef struct {
        logic               tick;
        logic               lp;
        logic signed [15:0] ls;
        logic               rp;
        logic signed [15:0] rs;
        logic               typed;
        footprint_t         fp;
    } row_t;

    localparam int CycleLimit = 3000000;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata;   // left_present, left_steer, right_present, right_steer
    logic        s_axis_tuser;   // req_type
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [95:0] m_axis_tdata;   // front_x, rear_x, front_left_y, front_right_y,
                                 // rear_right_y, rear_left_y

    steering_footprint_polygon dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    longint             wheel_base_q, half_width_q, front_len_q, rear_len_q;
    longint             margin_q, steer_limit_q;
    logic signed [15:0] heading_q;
    footprint_t         pending_fp[$];
    int                 mismatches;
    int                 cycle_count;
    bit                 quiet;
    bit                 stim_done;

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #4 clk = ~clk;
        end
    end

    function automatic longint clip(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic longint root_floor(longint unsigned n);
        longint unsigned res;
        longint unsigned bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > n)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (n >= res + bitv)
            begin
                n = n - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
                res = res >> 1;
            bitv = bitv >> 2;
        end
        return longint'(res);
    endfunction

    function automatic longint turn_overhang(longint mag);
        longint x, y, z, dx, dy, r, s, l, ov;
        x = CordGain;
        y = 0;
        if (mag < HundredthRad)
            return 0;
        if (mag > QuarterTurn)
            mag = QuarterTurn;
        z = mag * 65536;
        for (int i = 0; i < CordSteps; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0)
            begin
                x = x - dx;
                y = y + dy;
                z = z - longint'(atan_q29(i[3:0]));
            end
            else
            begin
                x = x + dx;
                y = y - dy;
                z = z + longint'(atan_q29(i[3:0]));
            end
        end
        if (x < 0)
            x = 0;
        r = (y > 0) ? (wheel_base_q * x) / y : 0;
        s = r + half_width_q;
        l = wheel_base_q + front_len_q;
        ov = root_floor(longint'(s * s + l * l)) - s;
        return clip(ov, 0, half_width_q);
    endfunction

    function automatic footprint_t predict_footprint();
        footprint_t f;
        longint a, ov, tail, lexp, rexp, rtail, ltail, width;
        a = heading_q;
        ov = turn_overhang(a < 0 ? -a : a);
        tail = (ov * 3) / 10;
        lexp = 0;
        rexp = 0;
        rtail = 0;
        ltail = 0;
        if (a >= HundredthRad)
            rexp = ov;
        else if (a <= -HundredthRad)
            lexp = ov;
        if (a > 0)
            rtail = tail;
        else if (a < 0)
            ltail = tail;
        width = half_width_q + margin_q;
        f.front_x       = 15'(clip(front_len_q + margin_q, 0, 32767));
        f.rear_x        = 16'(clip(-(rear_len_q + margin_q), -32768, 0));
        f.front_left_y  = 15'(clip(width + lexp, 0, 32767));
        f.front_right_y = 16'(clip(-(width + rexp), -32768, 0));
        f.rear_right_y  = 16'(clip(-(width + rtail), -32768, 0));
        f.rear_left_y   = 15'(clip(width + ltail, 0, 32767));
        return f;
    endfunction

    function automatic void update_heading(row_t it);
        longint a;
        a = heading_q;
        if (it.lp && it.rp)
            a = (longint'(it.ls) + longint'(it.rs)) >>> 1;
        else if (it.lp)
            a = it.ls;
        else if (it.rp)
            a = it.rs;
        a = clip(a, -steer_limit_q, steer_limit_q);
        heading_q = 16'(a);
    endfunction

    task automatic reg_write(input logic [2:0] idx, input logic [31:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            ADDR_WB:  wheel_base_q  = value[14:0];
            ADDR_HW:  half_width_q  = value[14:0];
            ADDR_FL:  front_len_q   = value[14:0];
            ADDR_RL:  rear_len_q    = value[14:0];
            ADDR_MG:  margin_q      = value[14:0];
            ADDR_LIM: steer_limit_q = value[13:0];
            default: ;
        endcase
    endtask

    task automatic wait_idle();
        while (pending_fp.size() != 0)
            @(posedge clk);
        repeat (150) @(posedge clk);
    endtask

    task automatic send_transfer(input row_t it);
        int gap;
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            gap = $urandom_range(1, 13);
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= it.tick;
        s_axis_tdata  <= {6'd0, it.rs, it.rp, it.ls, it.lp};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        if (it.tick)
            pending_fp.push_back(it.typed ? it.fp : predict_footprint());
        else
            update_heading(it);
    endtask

    function automatic row_t random_item();
        row_t it;
        it.tick  = ($urandom_range(0, 9) < 4);
        it.lp    = $urandom_range(0, 1);
        it.rp    = $urandom_range(0, 1);
        it.typed = 1'b0;
        case ($urandom_range(0, 3))
            0: begin it.ls = 16'($urandom()); it.rs = 16'($urandom()); end
            1: begin
                it.ls = 16'($signed($urandom_range(0, 200)) - 100);
                it.rs = 16'($signed($urandom_range(0, 200)) - 100);
            end
            default: begin
                it.ls = 16'($signed($urandom_range(0, 26000)) - 13000);
                it.rs = 16'($signed($urandom_range(0, 26000)) - 13000);
            end
        endcase
        return it;
    endfunction

    function automatic row_t mk(logic t, logic lp, int ls, logic rp, int rs);
        row_t it;
        it.tick  = t;
        it.lp    = lp;
        it.ls    = 16'(ls);
        it.rp    = rp;
        it.rs    = 16'(rs);
        it.typed = 1'b0;
        return it;
    endfunction

    initial
    begin
        row_t       steer_table[$];
        row_t       r;
        footprint_t straight;
        rst_n         = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tuser  = 1'b0;
        s_axis_tdata  = '0;
        quiet         = 1'b0;
        stim_done     = 1'b0;
        mismatches    = 0;
        wheel_base_q  = 2908;
        half_width_q  = 942;
        front_len_q   = 1229;
        rear_len_q    = 1229;
        margin_q      = 205;
        steer_limit_q = 4915;
        heading_q     = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        straight = '{15'd1434, -16'sd1434, 15'd1147, -16'sd1147, -16'sd1147, 15'd1147};
        r = mk(1, 0, 0, 0, 0); r.typed = 1'b1; r.fp = straight;
        steer_table.push_back(r);
        steer_table.push_back(mk(0, 1, 32767, 1, 32767));
        steer_table.push_back(mk(1, 0, 0, 0, 0));
        steer_table.push_back(mk(0, 1, -32768, 0, 5));
        steer_table.push_back(mk(1, 0, 0, 0, 0));
        steer_table.push_back(mk(0, 0, 100, 0, 100));
        steer_table.push_back(mk(1, 1, 0, 1, 0));
        steer_table.push_back(mk(0, 0, 7, 1, 81));
        r = mk(1, 0, 0, 0, 0); r.typed = 1'b1; r.fp = straight;
        steer_table.push_back(r);
        steer_table.push_back(mk(0, 0, 0, 1, 82));
        steer_table.push_back(mk(1, 0, 0, 0, 0));
        steer_table.push_back(mk(0, 1, -82, 0, 0));
        steer_table.push_back(mk(1, 0, 0, 0, 0));
        steer_table.push_back(mk(0, 1, -81, 0, 0));
        steer_table.push_back(mk(1, 0, 0, 0, 0));
        steer_table.push_back(mk(0, 1, -1, 1, 0));
        steer_table.push_back(mk(1, 0, 0, 0, 0));
        steer_table.push_back(mk(0, 1, 4000, 1, -2001));
        steer_table.push_back(mk(1, 0, 0, 0, 0));
        steer_table.push_back(mk(0, 1, 32767, 1, -32768));
        steer_table.push_back(mk(1, 1, -32768, 1, 32767));
        foreach (steer_table[i])
            send_transfer(steer_table[i]);

        for (int phase = 0; phase < 5; phase++)
        begin
            s_axis_tvalid <= 1'b0;
            wait_idle();
            case (phase)
                0:
                begin
                    for (int k = 0; k < 5; k++)
                        reg_write(k[2:0], 32'd32767);
                    reg_write(ADDR_LIM, 32'd12868);
                end
                1:
                begin
                    for (int k = 0; k < 6; k++)
                        reg_write(k[2:0], 32'd0);
                end
                2:
                begin
                    for (int k = 0; k < 6; k++)
                        reg_write(k[2:0], $urandom());
                    reg_write(3'd6, $urandom());
                    reg_write(3'd7, $urandom());
                end
                3:
                begin
                    reg_write(ADDR_WB, $urandom_range(500, 8000));
                    reg_write(ADDR_HW, $urandom_range(100, 3000));
                    reg_write(ADDR_FL, $urandom_range(100, 3000));
                    reg_write(ADDR_RL, $urandom_range(100, 3000));
                    reg_write(ADDR_MG, $urandom_range(0, 1000));
                    reg_write(ADDR_LIM, $urandom_range(82, 12868));
                end
                default:
                begin
                    quiet = 1'b1;
                    reg_write(ADDR_WB, 32'd2908);
                    reg_write(ADDR_HW, 32'd942);
                    reg_write(ADDR_FL, 32'd1229);
                    reg_write(ADDR_RL, 32'd1229);
                    reg_write(ADDR_MG, 32'd205);
                    reg_write(ADDR_LIM, 32'd4915);
                end
            endcase
            for (int n = 0; n < 250; n++)
                send_transfer(random_item());
        end
        s_axis_tvalid <= 1'b0;
        stim_done = 1'b1;
        while (pending_fp.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        if (mismatches == 0 && pending_fp.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        int  burst;
        bit  held;
        m_axis_tready = 1'b0;
        held = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (!held && cycle_count > 4000)
            begin
                held = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (600) @(posedge clk);
            end
            else if (!quiet && $urandom_range(0, 3) == 0)
            begin
                m_axis_tready <= 1'b0;
                burst = $urandom_range(1, 13);
                repeat (burst) @(posedge clk);
            end
            else
            begin
                m_axis_tready <= 1'b1;
                burst = $urandom_range(1, 20);
                repeat (burst) @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin
        footprint_t got;
        footprint_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.front_x       = m_axis_tdata[14:0];
            got.rear_x        = m_axis_tdata[30:15];
            got.front_left_y  = m_axis_tdata[45:31];
            got.front_right_y = m_axis_tdata[61:46];
            got.rear_right_y  = m_axis_tdata[77:62];
            got.rear_left_y   = m_axis_tdata[92:78];
            if (pending_fp.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected footprint transfer %h", m_axis_tdata);
            end
            else
            begin
                want = pending_fp.pop_front();
                if (got.front_x !== want.front_x || got.rear_x !== want.rear_x
                    || got.front_left_y !== want.front_left_y
                    || got.front_right_y !== want.front_right_y
                    || got.rear_right_y !== want.rear_right_y
                    || got.rear_left_y !== want.rear_left_y)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("footprint mismatch exp %0d %0d %0d %0d %0d %0d got %0d %0d %0d %0d %0d %0d",
                                 want.front_x, want.rear_x, want.front_left_y,
                                 want.front_right_y, want.rear_right_y, want.rear_left_y,
                                 got.front_x, got.rear_x, got.front_left_y,
                                 got.front_right_y, got.rear_right_y, got.rear_left_y);
                end
            end
        end
    end

    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count >= CycleLimit)
            begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

endmodule
